/* hdl/hsdc_pkg.sv */
// Shared constants for the distinct-value counter.
`timescale 1ns / 1ps

package hsdc_pkg;

   localparam int TABLE_SIZE_DEF = 1024;       // default slot count
   localparam int VALUE_W        = 32;         // width of one set element
   localparam int COUNT_W        = 11;         // width of the reported count
   localparam int REQ_DATA_W     = 32;         // request tdata width
   localparam int RSP_DATA_W     = 16;         // response tdata width, byte padded
   localparam int KEY_HASH_MULT  = 32'h9E37_79B1; // multiplicative hash constant

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1; // count saturates here

endpackage

/* hdl/hash_set_distinct_counter_unit.sv */
// Distinct-value counter: hashed open-addressed set with linear probing.
`timescale 1ns / 1ps
//
// Usage
//   Request channel (req_*): one 32-bit set element per request in req_tdata,
//   req_tlast high on the final element of the set. Elements are taken one at
//   a time; req_tready is high only while the unit waits for the next element.
//   Response channel (rsp_*): one response per set, after its last element:
//   tdata[10:0] the number of distinct elements (saturating at 2047),
//   tdata[11] set if the table was full when a new element arrived.
// Timing
//   An element passes through accept, hash map, table read and compare; each
//   further probe adds one more read and compare. The probe loop on the
//   single read port of the slot table sets this pace. A full table costs up
//   to TABLE_SIZE probes.
//   The response is loaded once the output register is free after the last
//   element settles. The slot table is then swept clear, one slot a cycle,
//   with req_tready low. The same sweep runs right after reset.
// Stalls
//   The response sits in an output register; while it waits the unit keeps
//   taking elements of the next set. Only the close of that next set waits
//   for rsp_tready.
// Reset
//   Synchronous, active high: clears the count, flag, response valid and
//   starts the clearing sweep.
module hash_set_distinct_counter_unit
   import hsdc_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] value
   input  logic                  req_tlast,   // last element of the set
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [10:0] distinct_count, [11] overflow, zeros
);

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
   localparam int SLOT_W = VALUE_W + 1;        // {valid, key}
   localparam int PAD_W  = RSP_DATA_W - COUNT_W - 1;
   localparam int MAP_W  = 33;                 // 16-bit fold times up to 17-bit size

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_SIZE);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_READ,
      ST_CHECK,
      ST_RESULT,
      ST_CLEAR
   } state_type;

   // slot table: bit VALUE_W is the valid flag
   logic [SLOT_W-1:0] slot_mem [TABLE_SIZE];
   logic [SLOT_W-1:0] rd_q_ff;

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic               last_ff, last_in;
   logic [VALUE_W-1:0] hash_ff, hash_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   probe_ff, probe_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [SLOT_W-1:0]  wr_data;

   logic [15:0]        hash_fold;
   logic [MAP_W-1:0]   map_prod;
   logic [IDX_W-1:0]   idx_next;
   logic               slot_used;
   logic               key_hit;
   logic [COUNT_W-1:0] count_sat;

   // fold the hash and scale it into [0, TABLE_SIZE) by a multiply-high
   assign hash_fold = hash_ff[31:16] ^ hash_ff[15:0];
   assign map_prod  = MAP_W'(hash_fold) * MAP_W'(TABLE_SIZE);

   assign idx_next  = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
   assign slot_used = rd_q_ff[VALUE_W];
   assign key_hit   = (rd_q_ff[VALUE_W-1:0] == key_ff);

   assign count_sat = (32'(count_ff) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(count_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_ovf_ff, rsp_count_ff};

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      hash_in      = hash_ff;
      idx_in       = idx_ff;
      probe_in     = probe_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = {1'b1, key_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               key_in   = req_tdata[VALUE_W-1:0];
               last_in  = req_tlast;
               hash_in  = VALUE_W'(req_tdata[VALUE_W-1:0] * VALUE_W'(KEY_HASH_MULT));
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            idx_in   = map_prod[16 +: IDX_W];
            probe_in = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = last_ff ? ST_RESULT : ST_IDLE;
            if (!slot_used) begin
               // empty slot: claim it
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end else if (key_hit) begin
               // already in the set
            end else if (probe_ff == IDX_LAST) begin
               // every slot probed, none free
               ovf_in = 1'b1;
            end else begin
               // collision: step to the next slot and read it right away
               probe_in = probe_ff + 1'b1;
               idx_in   = idx_next;
               rd_en    = 1'b1;
               rd_addr  = idx_next;
               state_in = ST_CHECK;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_sat;
               rsp_ovf_in   = ovf_ff;
               count_in     = '0;
               ovf_in       = 1'b0;
               clr_in       = '0;
               state_in     = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            if (clr_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state machine and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      last_ff      <= last_in;
      hash_ff      <= hash_in;
      idx_ff       <= idx_in;
      probe_ff     <= probe_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // slot table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= slot_mem[rd_addr];
      end
   end

   // the count cannot pass the number of slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("distinct count above table size");

   // overflow only once every slot holds a key
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == CNT_FULL))
      else $error("overflow flagged with free slots");

   // loading a response starts a fresh set
   a_rsp_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && (!rsp_valid_ff || rsp_tready))
         |=> (count_ff == '0 && !ovf_ff && rsp_valid_ff && state_ff == ST_CLEAR))
      else $error("set state not cleared after response");

   // the sweep ends only at the last slot
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_ff != IDX_LAST) |=> (state_ff == ST_CLEAR))
      else $error("clearing sweep left early");

endmodule

/* sim/tb_hash_set_distinct_counter_unit.sv */
// Self-checking testbench for the distinct-value counter unit.
`timescale 1ns / 1ps

module tb_hash_set_distinct_counter_unit;
   import hsdc_pkg::*;

   localparam int SLOTS           = TABLE_SIZE_DEF;
   localparam int RSP_HOLD_CYCLES = 3000;        // long enough to back up two set closes
   localparam int DRAIN_CYCLES    = SLOTS + 64;  // clearing sweep plus pipeline
   localparam int RANDOM_ELEMENTS = 700;
   localparam int RANDOM_SETS_MIN = 48;
   localparam int TIMEOUT_NS      = 8_000_000;

   typedef struct packed {
      logic [COUNT_W-1:0] distinct_count;
      logic               overflow;
   } set_summary_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [31:0] value
   logic                  req_tlast;   // last element of the set
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [10:0] distinct_count, [11] overflow, zeros

   // predictor state: members of the open set, their count, table-full flag
   bit              set_members [bit [VALUE_W-1:0]];
   int unsigned     member_count;
   bit              set_overflowed;
   set_summary_type expected_summaries [$];

   int   sender_idle_pct;
   int   rsp_idle_pct;
   logic rsp_hold_active;
   event rsp_hold_start;
   int   elements_sent;
   int   sets_checked;
   int   mismatches;

   hash_set_distinct_counter_unit #(.TABLE_SIZE(SLOTS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Fold one accepted element into the open set; on the closing element,
   // queue the summary the unit must report and start a fresh set.
   function automatic void absorb_element(input logic [VALUE_W-1:0] v, input logic l);
      set_summary_type s;
      if (!set_members.exists(v)) begin
         if (member_count < SLOTS) begin
            set_members[v] = 1'b1;
            member_count++;
         end else begin
            set_overflowed = 1'b1;   // no empty slot: newcomer dropped
         end
      end
      if (l) begin
         s.distinct_count = (member_count > COUNT_MAX) ? COUNT_MAX
                                                       : member_count[COUNT_W-1:0];
         s.overflow       = set_overflowed;
         expected_summaries.push_back(s);
         set_members.delete();
         member_count   = 0;
         set_overflowed = 1'b0;
      end
   endfunction

   // Called in the time step of a rising edge. Valid is only lowered for an
   // idle gap, never in the step where it is raised again.
   task automatic send_element(input logic [VALUE_W-1:0] v, input logic l);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      absorb_element(v, l);
      elements_sent++;
   endtask

   task automatic send_set(input logic [VALUE_W-1:0] vals [$]);
      foreach (vals[i]) send_element(vals[i], i == vals.size() - 1);
   endtask

   function automatic void draw_distinct(input int n, ref logic [VALUE_W-1:0] q [$]);
      bit                 taken [bit [VALUE_W-1:0]];
      logic [VALUE_W-1:0] v;
      q.delete();
      while (q.size() < n) begin
         v = $urandom;
         if (!taken.exists(v)) begin
            taken[v] = 1'b1;
            q.push_back(v);
         end
      end
   endfunction

   // Mostly short sets, a few long ones that build probe chains.
   function automatic int random_set_size();
      int r;
      r = $urandom_range(99);
      if (r < 60) return $urandom_range(8, 1);
      if (r < 90) return $urandom_range(40, 9);
      return $urandom_range(150, 41);
   endfunction

   task automatic send_random_set(input int n);
      logic [VALUE_W-1:0] vals [$];
      logic [VALUE_W-1:0] v;
      int                 r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (i > 0 && r < 35) begin
            v = vals[$urandom_range(vals.size() - 1)];   // repeat within the set
         end else if (r < 45) begin
            case ($urandom_range(3))
               0:       v = '0;
               1:       v = '1;
               2:       v = 32'h8000_0000;
               default: v = 32'h7FFF_FFFF;
            endcase
         end else if (r < 60) begin
            v = $urandom_range(15);
         end else begin
            v = $urandom;
         end
         vals.push_back(v);
      end
      send_set(vals);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_single_element_sets();
      logic [VALUE_W-1:0] q [$];
      q = '{32'h0000_0000};  send_set(q);
      q = '{32'hFFFF_FFFF};  send_set(q);
      q = '{32'h8000_0000};  send_set(q);
      q = '{32'h7FFF_FFFF};  send_set(q);
      q = '{32'h0000_0001};  send_set(q);
   endtask

   task automatic test_repeated_values();
      logic [VALUE_W-1:0] q [$];
      q = '{32'd5, 32'd5, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      send_set(q);
      // closing element repeats an earlier one
      q = '{32'h1234_5678, 32'h8765_4321, 32'h1234_5678};
      send_set(q);
      // values one bit apart stay distinct
      q = '{32'h0, 32'h1, 32'h8000_0000, 32'h4000_0000, 32'h0, 32'h1};
      send_set(q);
   endtask

   task automatic test_table_full();
      logic [VALUE_W-1:0] pool  [$];
      logic [VALUE_W-1:0] set_q [$];
      draw_distinct(SLOTS + 2, pool);
      // exactly full, repeats still find their match: no overflow
      for (int i = 0; i < SLOTS; i++) set_q.push_back(pool[i]);
      set_q.push_back(pool[0]);
      set_q.push_back(pool[SLOTS-1]);
      send_set(set_q);
      // full table: newcomers dropped, the closing one as well
      set_q.delete();
      for (int i = 0; i < SLOTS; i++) set_q.push_back(pool[i]);
      set_q.push_back(pool[SLOTS]);
      set_q.push_back(pool[3]);
      set_q.push_back(pool[SLOTS+1]);
      send_set(set_q);
      // next set must start from a clean table
      set_q = '{pool[SLOTS], pool[7], pool[SLOTS]};
      send_set(set_q);
   endtask

   // Receiver stalls while sets keep coming: the first summary parks in the
   // output register, the second close backs up the request side.
   task automatic test_response_backpressure();
      int saved_pct;
      saved_pct       = sender_idle_pct;
      sender_idle_pct = 0;
      -> rsp_hold_start;
      for (int i = 0; i < 4; i++) send_random_set($urandom_range(8, 3));
      sender_idle_pct = saved_pct;
   endtask

   task automatic test_random_sets();
      int start_elements;
      int sets_sent;
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin sender_idle_pct = 28; rsp_idle_pct = 83; end
            1: begin sender_idle_pct = 83; rsp_idle_pct = 28; end
            default: begin sender_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         start_elements = elements_sent;
         sets_sent      = 0;
         while (elements_sent - start_elements < RANDOM_ELEMENTS / 3 ||
                sets_sent < RANDOM_SETS_MIN / 3) begin
            send_random_set(random_set_size());
            sets_sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_active) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always begin
      @(rsp_hold_start);
      rsp_hold_active <= 1'b1;
      repeat (RSP_HOLD_CYCLES) @(posedge clock);
      rsp_hold_active <= 1'b0;
   end

   always @(posedge clock) begin : check_responses
      set_summary_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_summaries.size() == 0) begin
            $error("response with no set pending: rsp_tdata=%h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_summaries.pop_front();
            if (rsp_tdata[COUNT_W-1:0] !== want.distinct_count) begin
               $error("distinct_count: expected %0d, got %0d",
                      want.distinct_count, rsp_tdata[COUNT_W-1:0]);
               mismatches++;
            end
            if (rsp_tdata[COUNT_W] !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_tdata[COUNT_W]);
               mismatches++;
            end
            sets_checked++;
         end
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tlast       = 1'b0;
      rsp_hold_active = 1'b0;
      member_count    = 0;
      set_overflowed  = 1'b0;
      elements_sent   = 0;
      sets_checked    = 0;
      mismatches      = 0;
      sender_idle_pct = 28;
      rsp_idle_pct    = 83;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_single_element_sets();
      test_repeated_values();
      test_table_full();
      test_response_backpressure();
      test_random_sets();

      req_tvalid <= 1'b0;
      while (expected_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d elements in %0d checked sets: single and repeated values,",
               elements_sent, sets_checked);
      $display("an exactly full and an overflowing table, and a %0d-cycle response stall.",
               RSP_HOLD_CYCLES);
      if (mismatches == 0 && expected_summaries.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
hdl/hsdc_pkg.sv
hdl/hash_set_distinct_counter_unit.sv
sim/tb_hash_set_distinct_counter_unit.sv
